[src/hct_pkg.sv]
// hct_pkg: shared types, codes and microcode table for the console timer
// depends on nothing; used by the interfaces, the sequencer and the top level
`timescale 1ns / 1ps
`default_nettype none

package hct_pkg;

   // payload widths
   localparam int CMD_W    = 3;
   localparam int CYCLES_W = 5;
   localparam int BYTE_W   = 8;
   localparam int SPEED_W  = 2;

   // default timing
   localparam int DEF_DIVIDER_PERIOD = 4;
   localparam int DEF_FASTEST_PERIOD = 8;

   // control byte layout
   localparam int CTRL_ENABLE_BIT = 2;
   localparam logic [SPEED_W-1:0] SPEED_RESET = 2'd3;

   // speed codes
   localparam logic [SPEED_W-1:0] SPEED_X64 = 2'd0;
   localparam logic [SPEED_W-1:0] SPEED_X1  = 2'd1;
   localparam logic [SPEED_W-1:0] SPEED_X4  = 2'd2;
   localparam logic [SPEED_W-1:0] SPEED_X16 = 2'd3;

   localparam logic [BYTE_W-1:0] COUNTER_MAX = 8'hFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK          = 3'd0,
      CMD_CLEAR_DIV     = 3'd1,
      CMD_WRITE_COUNTER = 3'd2,
      CMD_WRITE_MODULO  = 3'd3,
      CMD_WRITE_CONTROL = 3'd4
   } cmd_type;

   // program addresses
   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_DIVIDE = 3'd1,
      ST_TLOOP  = 3'd2,
      ST_WRITE  = 3'd3,
      ST_EMIT   = 3'd4
   } step_type;

   // how the next address is chosen
   typedef enum logic [1:0] {
      JMP_ACCEPT = 2'd0,  // on a beat: tick to tgt_a, others to tgt_b
      JMP_DUE    = 2'd1,  // timer period due: tgt_a, else tgt_b
      JMP_ALWAYS = 2'd2,
      JMP_EMIT   = 2'd3   // to tgt_a once the result register is free
   } jump_type;

   typedef struct packed {
      logic     op_load;   // take a beat, latch it, add the tick
      logic     op_div;    // apply divider quotient
      logic     op_timer;  // one counter step if due
      logic     op_write;  // apply a write command
      logic     op_emit;   // load the result register
      jump_type jump;
      step_type tgt_a;
      step_type tgt_b;
   } ctrl_type;

   // microcode table
   function automatic ctrl_type ucode_rom(input step_type step);
      ctrl_type w;
      w = '{op_load: 1'b0, op_div: 1'b0, op_timer: 1'b0, op_write: 1'b0,
            op_emit: 1'b0, jump: JMP_ALWAYS, tgt_a: ST_IDLE, tgt_b: ST_IDLE};
      unique case (step)
         ST_IDLE: begin
            w.op_load = 1'b1;
            w.jump    = JMP_ACCEPT;
            w.tgt_a   = ST_DIVIDE;
            w.tgt_b   = ST_WRITE;
         end
         ST_DIVIDE: begin
            w.op_div   = 1'b1;
            w.op_timer = 1'b1;
            w.jump     = JMP_DUE;
            w.tgt_a    = ST_TLOOP;
            w.tgt_b    = ST_EMIT;
         end
         ST_TLOOP: begin
            w.op_timer = 1'b1;
            w.jump     = JMP_DUE;
            w.tgt_a    = ST_TLOOP;
            w.tgt_b    = ST_EMIT;
         end
         ST_WRITE: begin
            w.op_write = 1'b1;
            w.jump     = JMP_ALWAYS;
            w.tgt_a    = ST_EMIT;
         end
         ST_EMIT: begin
            w.op_emit = 1'b1;
            w.jump    = JMP_EMIT;
            w.tgt_a   = ST_IDLE;
         end
         default: begin
            w.jump  = JMP_ALWAYS;
            w.tgt_a = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[src/hct_if.sv]
// hct_if: request and response channel interfaces of the console timer
// depends on hct_pkg for payload widths
`timescale 1ns / 1ps
`default_nettype none

interface hct_req_if;
   import hct_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]    cmd;
   logic [CYCLES_W-1:0] cycles;
   logic [BYTE_W-1:0]   write_data;

   modport source (output valid, output cmd, output cycles, output write_data,
                   input ready);
   modport sink   (input valid, input cmd, input cycles, input write_data,
                   output ready);
endinterface

interface hct_rsp_if;
   import hct_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] divider_value;
   logic [BYTE_W-1:0] counter_value;
   logic              timer_interrupt;

   modport source (output valid, output divider_value, output counter_value,
                   output timer_interrupt, input ready);
   modport sink   (input valid, input divider_value, input counter_value,
                   input timer_interrupt, output ready);
endinterface

`default_nettype wire

[src/hct_seq.sv]
// hct_seq: step counter and jump logic that runs the microcode table
// depends on hct_pkg (step_type, ctrl_type, ucode_rom)
`timescale 1ns / 1ps
`default_nettype none

module hct_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              is_tick,
   input  logic              due,
   input  logic              rsp_free,
   output hct_pkg::ctrl_type ctrl
);
   import hct_pkg::*;

   step_type pc_ff;
   step_type pc_in;

   // step register
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // control word fetch and next address
   always_comb begin
      ctrl  = ucode_rom(pc_ff);
      pc_in = pc_ff;
      unique case (ctrl.jump)
         JMP_ACCEPT: begin
            if (req_valid) begin
               pc_in = is_tick ? ctrl.tgt_a : ctrl.tgt_b;
            end
         end
         JMP_DUE: begin
            pc_in = due ? ctrl.tgt_a : ctrl.tgt_b;
         end
         JMP_ALWAYS: begin
            pc_in = ctrl.tgt_a;
         end
         JMP_EMIT: begin
            if (rsp_free) begin
               pc_in = ctrl.tgt_a;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

[src/handheld_console_timer.sv]
// handheld_console_timer: divider and programmable timer, top level datapath
// depends on hct_pkg, hct_if (channels) and hct_seq (microcode sequencer)
`timescale 1ns / 1ps
`default_nettype none

// One command beat is taken at a time. A non-tick command goes from IDLE through
// WRITE to EMIT. A tick goes from IDLE through DIVIDE, where the divider is settled
// in a single step by a reciprocal multiply, and through TLOOP while a timer period
// is due, to EMIT; the timer loop of the sequencer does one counter step per cycle.
// EMIT loads the result register once that register is free. With default timing
// a single tick causes at most four counter steps; after a speed change to a faster
// period a single tick can step the counter many more times. The result
// register frees the input side, so the next command is accepted while a finished
// result is still waiting to be taken.
module handheld_console_timer #(
   parameter int DIVIDER_PERIOD = hct_pkg::DEF_DIVIDER_PERIOD,
   parameter int FASTEST_PERIOD = hct_pkg::DEF_FASTEST_PERIOD
) (
   input  logic clock,
   input  logic reset,
   hct_req_if.sink   req_ch,
   hct_rsp_if.source rsp_ch
);
   import hct_pkg::*;

   localparam int DPW    = (DIVIDER_PERIOD > 1) ? $clog2(DIVIDER_PERIOD) : 1;
   localparam int SUMW   = $clog2(DIVIDER_PERIOD + 32);
   localparam int RECIP  = (1 << SUMW) / DIVIDER_PERIOD;
   localparam int PRODW  = 2 * SUMW + 1;
   localparam int TPW    = $clog2(64 * FASTEST_PERIOD + 32);

   ctrl_type ctrl;
   logic     accept;
   logic     due;
   logic     rsp_free;

   // architectural state
   logic [BYTE_W-1:0]  divider_ff,   divider_in;
   logic [DPW-1:0]     dpre_ff,      dpre_in;
   logic [BYTE_W-1:0]  counter_ff,   counter_in;
   logic [BYTE_W-1:0]  reload_ff,    reload_in;
   logic [TPW-1:0]     tpre_ff,      tpre_in;
   logic               enabled_ff,   enabled_in;
   logic [SPEED_W-1:0] speed_ff,     speed_in;

   // per-item work registers
   cmd_type            cmd_ff;
   logic [BYTE_W-1:0]  data_ff;
   logic [SUMW-1:0]    dsum_ff;
   logic [PRODW-1:0]   dprod_ff;
   logic               irq_ff,       irq_in;

   // result register
   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  rsp_div_ff;
   logic [BYTE_W-1:0]  rsp_cnt_ff;
   logic               rsp_irq_ff;

   logic [SUMW-1:0]    dsum_in;
   logic [SUMW:0]      quot0;
   logic [SUMW-1:0]    rem0;
   logic               rem_over;
   logic [TPW-1:0]     period;

   hct_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .is_tick   (cmd_type'(req_ch.cmd) == CMD_TICK),
      .due       (due),
      .rsp_free  (rsp_free),
      .ctrl      (ctrl)
   );

   assign req_ch.ready = ctrl.op_load;
   assign accept       = req_ch.valid & ctrl.op_load;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // selected timer period
   always_comb begin
      unique case (speed_ff)
         SPEED_X64: period = TPW'(64 * FASTEST_PERIOD);
         SPEED_X1:  period = TPW'(FASTEST_PERIOD);
         SPEED_X4:  period = TPW'(4 * FASTEST_PERIOD);
         SPEED_X16: period = TPW'(16 * FASTEST_PERIOD);
         default:   period = TPW'(16 * FASTEST_PERIOD);
      endcase
   end

   assign due = enabled_ff && (tpre_ff >= period);

   // divider prescaler sum and its reciprocal product
   assign dsum_in = SUMW'(dpre_ff) + SUMW'(req_ch.cycles);

   // quotient estimate, low by at most one
   assign quot0    = dprod_ff[PRODW-1:SUMW];
   assign rem0     = dsum_ff - SUMW'(quot0 * DIVIDER_PERIOD);
   assign rem_over = rem0 >= SUMW'(DIVIDER_PERIOD);

   // datapath next state
   always_comb begin
      divider_in = divider_ff;
      dpre_in    = dpre_ff;
      counter_in = counter_ff;
      reload_in  = reload_ff;
      tpre_in    = tpre_ff;
      enabled_in = enabled_ff;
      speed_in   = speed_ff;
      irq_in     = irq_ff;

      // beat taken: clear irq; if enabled, add tick cycles to the prescaler
      if (accept) begin
         irq_in = 1'b0;
         if (cmd_type'(req_ch.cmd) == CMD_TICK && enabled_ff) begin
            tpre_in = tpre_ff + TPW'(req_ch.cycles);
         end
      end

      // divider advance by whole periods
      if (ctrl.op_div) begin
         divider_in = divider_ff + BYTE_W'(quot0) + BYTE_W'(rem_over);
         dpre_in    = rem_over ? DPW'(rem0 - SUMW'(DIVIDER_PERIOD)) : DPW'(rem0);
      end

      // one timer period
      if (ctrl.op_timer && due) begin
         tpre_in = tpre_ff - period;
         if (counter_ff == COUNTER_MAX) begin
            counter_in = reload_ff;
            irq_in     = 1'b1;
         end else begin
            counter_in = counter_ff + 1'b1;
         end
      end

      // register writes
      if (ctrl.op_write) begin
         unique case (cmd_ff)
            CMD_CLEAR_DIV:     divider_in = '0;
            CMD_WRITE_COUNTER: counter_in = data_ff;
            CMD_WRITE_MODULO:  reload_in  = data_ff;
            CMD_WRITE_CONTROL: begin
               enabled_in = data_ff[CTRL_ENABLE_BIT];
               speed_in   = data_ff[SPEED_W-1:0];
               if (!data_ff[CTRL_ENABLE_BIT]) begin
                  tpre_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // architectural state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= '0;
         dpre_ff    <= '0;
         counter_ff <= '0;
         reload_ff  <= '0;
         tpre_ff    <= '0;
         enabled_ff <= 1'b0;
         speed_ff   <= SPEED_RESET;
         irq_ff     <= 1'b0;
      end else begin
         divider_ff <= divider_in;
         dpre_ff    <= dpre_in;
         counter_ff <= counter_in;
         reload_ff  <= reload_in;
         tpre_ff    <= tpre_in;
         enabled_ff <= enabled_in;
         speed_ff   <= speed_in;
         irq_ff     <= irq_in;
      end
   end

   // beat capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= cmd_type'(req_ch.cmd);
         data_ff  <= req_ch.write_data;
         dsum_ff  <= dsum_in;
         dprod_ff <= PRODW'(dsum_in) * PRODW'(RECIP);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.op_emit && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op_emit && rsp_free) begin
         rsp_div_ff <= divider_ff;
         rsp_cnt_ff <= counter_ff;
         rsp_irq_ff <= irq_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.divider_value   = rsp_div_ff;
   assign rsp_ch.counter_value   = rsp_cnt_ff;
   assign rsp_ch.timer_interrupt = rsp_irq_ff;

endmodule

`default_nettype wire

[src/hct_checker.sv]
// hct_checker: port-level assertions for the console timer, bound to the top
// depends on hct_pkg for payload widths and on handheld_console_timer
`timescale 1ns / 1ps
`default_nettype none

module hct_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [hct_pkg::BYTE_W-1:0] rsp_divider_value,
   input logic [hct_pkg::BYTE_W-1:0] rsp_counter_value,
   input logic                       rsp_timer_interrupt
);
   import hct_pkg::*;

   // result channel empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one command in flight: no new beat in the cycle after a taken beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a command is in flight");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_divider_value)
         && $stable(rsp_counter_value) && $stable(rsp_timer_interrupt)))
      else $error("result payload changed while stalled");

endmodule

bind handheld_console_timer hct_checker u_hct_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_divider_value   (rsp_ch.divider_value),
   .rsp_counter_value   (rsp_ch.counter_value),
   .rsp_timer_interrupt (rsp_ch.timer_interrupt)
);

`default_nettype wire

[verif/hct_timer_checker.sv]
// hct_timer_checker: watches the command and status channels of the console timer,
// predicts each status beat and compares it field by field
// depends on hct_pkg (codes, widths, default timing) and hct_if (channel interfaces)
`timescale 1ns / 1ps

module hct_timer_checker (
   input  logic clock,
   input  logic reset,
   hct_req_if   req_ch,
   hct_rsp_if   rsp_ch,
   output int   mismatch_count,
   output int   pending_count
);
   import hct_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] divider;
      logic [BYTE_W-1:0] counter;
      logic              irq;
   } timer_status_type;

   // predicted timer state
   logic [BYTE_W-1:0]  div_count;
   logic [1:0]         div_prescale;
   logic [BYTE_W-1:0]  tima;
   logic [BYTE_W-1:0]  modulo;
   logic [9:0]         timer_prescale;
   logic               timer_on;
   logic [SPEED_W-1:0] speed_sel;

   // status beats still owed by the block, oldest first
   timer_status_type status_due[$];

   task automatic note_failure(input string msg);
      $display("%0t ns  checker: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic int speed_period(input logic [SPEED_W-1:0] speed);
      case (speed)
         SPEED_X64: return DEF_FASTEST_PERIOD * 64;
         SPEED_X1:  return DEF_FASTEST_PERIOD;
         SPEED_X4:  return DEF_FASTEST_PERIOD * 4;
         default:   return DEF_FASTEST_PERIOD * 16;
      endcase
   endfunction

   // advance the predicted state by one command and return its status
   function automatic timer_status_type apply_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [CYCLES_W-1:0] cyc,
                                                      input logic [BYTE_W-1:0] data);
      timer_status_type st;
      int               dpre;
      int               tpre;
      int               period;
      logic             irq;
      irq = 1'b0;
      case (cmd)
         CMD_TICK: begin
            // divider runs whether or not the timer is on
            dpre = int'(div_prescale) + int'(cyc);
            while (dpre >= DEF_DIVIDER_PERIOD) begin
               div_count = div_count + 8'd1;
               dpre      = dpre - DEF_DIVIDER_PERIOD;
            end
            div_prescale = 2'(dpre);
            if (timer_on) begin
               period = speed_period(speed_sel);
               tpre   = int'(timer_prescale) + int'(cyc);
               // one counter step per whole period, reload on overflow
               while (tpre >= period) begin
                  if (tima == COUNTER_MAX) begin
                     tima = modulo;
                     irq  = 1'b1;
                  end else begin
                     tima = tima + 8'd1;
                  end
                  tpre = tpre - period;
               end
               timer_prescale = 10'(tpre);
            end
         end
         CMD_CLEAR_DIV:     div_count = '0;
         CMD_WRITE_COUNTER: tima = data;
         CMD_WRITE_MODULO:  modulo = data;
         CMD_WRITE_CONTROL: begin
            timer_on = data[CTRL_ENABLE_BIT];
            if (!timer_on) timer_prescale = '0;
            speed_sel = data[SPEED_W-1:0];
         end
         default: ;
      endcase
      st.divider = div_count;
      st.counter = tima;
      st.irq     = irq;
      return st;
   endfunction

   // compare status beats, then predict newly accepted commands
   always @(posedge clock) begin
      timer_status_type want;
      if (reset) begin
         div_count      = '0;
         div_prescale   = '0;
         tima           = '0;
         modulo         = '0;
         timer_prescale = '0;
         timer_on       = 1'b0;
         speed_sel      = SPEED_RESET;
         status_due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (status_due.size() == 0) begin
               note_failure($sformatf("status beat div=%0d cnt=%0d irq=%0d with nothing due",
                                      rsp_ch.divider_value, rsp_ch.counter_value,
                                      rsp_ch.timer_interrupt));
            end else begin
               want = status_due.pop_front();
               if (rsp_ch.divider_value !== want.divider)
                  note_failure($sformatf("divider_value got %0d want %0d",
                                         rsp_ch.divider_value, want.divider));
               if (rsp_ch.counter_value !== want.counter)
                  note_failure($sformatf("counter_value got %0d want %0d",
                                         rsp_ch.counter_value, want.counter));
               if (rsp_ch.timer_interrupt !== want.irq)
                  note_failure($sformatf("timer_interrupt got %0b want %0b",
                                         rsp_ch.timer_interrupt, want.irq));
            end
         end
         if (req_ch.valid && req_ch.ready)
            status_due.push_back(apply_command(req_ch.cmd, req_ch.cycles,
                                               req_ch.write_data));
      end
      pending_count = status_due.size();
   end

endmodule

[verif/tb_handheld_console_timer.sv]
// tb_handheld_console_timer: drives command beats into the console timer with random
// gaps and backpressure, and gives the verdict from the checker's counts
// depends on hct_pkg, hct_if, handheld_console_timer and hct_timer_checker
`timescale 1ns / 1ps

module tb_handheld_console_timer;
   import hct_pkg::*;

   localparam int ITEM_TARGET    = 850;
   localparam int HOLD_CYCLES    = 160;
   localparam int HOLD_AT_A      = 300;
   localparam int HOLD_AT_B      = 650;
   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
   localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   int   sent_items;
   int   idle_cycles;
   bit   burst_mode;
   bit   hold_request;

   hct_req_if req_ch ();
   hct_rsp_if rsp_ch ();

   handheld_console_timer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   hct_timer_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // one command beat, after a random gap
   task automatic send_command(input logic [CMD_W-1:0] cmd,
                               input logic [CYCLES_W-1:0] cyc,
                               input logic [BYTE_W-1:0] data);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 4);
      if (sent_items == HOLD_AT_A || sent_items == HOLD_AT_B) hold_request = 1'b1;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= cmd;
      req_ch.cycles     <= cyc;
      req_ch.write_data <= data;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      sent_items++;
   endtask

   task automatic tick(input logic [CYCLES_W-1:0] cyc);
      send_command(CMD_TICK, cyc, BYTE_W'($urandom));
   endtask

   task automatic write_reg(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
      send_command(cmd, CYCLES_W'($urandom), data);
   endtask

   // control byte with random spare bits
   function automatic logic [BYTE_W-1:0] ctrl_byte(input logic on,
                                                   input logic [SPEED_W-1:0] speed);
      logic [BYTE_W-1:0] b;
      b                  = BYTE_W'($urandom);
      b[CTRL_ENABLE_BIT] = on;
      b[SPEED_W-1:0]     = speed;
      return b;
   endfunction

   // status side: random stalls, plus long holds on request
   initial begin : status_sink
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(negedge clock); while (reset);
      @(posedge clock);
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, 4);
         if (hold_request) begin
            hold_request = 1'b0;
            stall        = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(negedge clock); while (!rsp_ch.valid);
         @(posedge clock);
      end
   end

   // command stimulus and verdict
   initial begin : stimulus
      int steps;
      int pick;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.cmd        <= '0;
      req_ch.cycles     <= '0;
      req_ch.write_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // state after reset, divider running with the timer off
      tick(5'd0);
      tick(5'd31);
      for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++)
         send_command(CMD_W'(c), CYCLES_W'($urandom), BYTE_W'($urandom));
      // fastest period with all spare bits set, overflow into the modulo
      write_reg(CMD_WRITE_CONTROL, 8'hFD);
      write_reg(CMD_WRITE_COUNTER, 8'hFE);
      write_reg(CMD_WRITE_MODULO, 8'hA5);
      tick(5'd31);
      // divider clear, disable clears prescaler, exact period boundary
      write_reg(CMD_CLEAR_DIV, BYTE_W'($urandom));
      write_reg(CMD_WRITE_CONTROL, 8'h00);
      write_reg(CMD_WRITE_CONTROL, ctrl_byte(1'b1, SPEED_X1));
      tick(5'd8);
      // build prescaler at the slowest speed, then switch to the fastest
      write_reg(CMD_WRITE_CONTROL, ctrl_byte(1'b1, SPEED_X64));
      write_reg(CMD_WRITE_COUNTER, 8'hF0);
      repeat (8) tick(5'd31);
      write_reg(CMD_WRITE_CONTROL, ctrl_byte(1'b1, SPEED_X1));
      tick(5'd0);
      // disabled with every other bit set
      write_reg(CMD_WRITE_CONTROL, 8'hFB);
      tick(5'd31);

      // random scenarios: set up the timer, then a run of mostly ticks
      while (sent_items < ITEM_TARGET) begin
         burst_mode = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 3) != 0)
            write_reg(CMD_WRITE_CONTROL,
                      ctrl_byte($urandom_range(0, 7) != 0, SPEED_W'($urandom)));
         if ($urandom_range(0, 2) == 0)
            write_reg(CMD_WRITE_MODULO, $urandom_range(0, 1) ? BYTE_W'($urandom)
                                                             : BYTE_W'($urandom_range(224, 255)));
         if ($urandom_range(0, 1) == 0)
            write_reg(CMD_WRITE_COUNTER, $urandom_range(0, 2) ? BYTE_W'($urandom_range(248, 255))
                                                              : BYTE_W'($urandom));
         steps = $urandom_range(2, 12);
         for (int i = 0; i < steps; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
               tick(CYCLES_W'($urandom));
            else if (pick == 15)
               write_reg(CMD_CLEAR_DIV, BYTE_W'($urandom));
            else if (pick == 16)
               send_command(CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED)),
                            CYCLES_W'($urandom), BYTE_W'($urandom));
            else if (pick == 17)
               write_reg(CMD_WRITE_MODULO, BYTE_W'($urandom));
            else if (pick == 18)
               write_reg(CMD_WRITE_COUNTER, BYTE_W'($urandom));
            else
               write_reg(CMD_WRITE_CONTROL, ctrl_byte(1'b1, SPEED_W'($urandom)));
         end
      end
      req_ch.valid <= 1'b0;

      // drain, then let a stray beat show up
      do @(negedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[handheld_console_timer.f]
src/hct_pkg.sv
src/hct_if.sv
src/hct_seq.sv
src/handheld_console_timer.sv
src/hct_checker.sv
verif/hct_timer_checker.sv
verif/tb_handheld_console_timer.sv
